@@ hdl/ifdf_pkg.sv @@
// Shared types and constants for the fixed-width decimal integer formatter.
// No dependencies.
package ifdf_pkg;

    localparam int unsigned NUM_BITS        = 32;
    localparam int unsigned NUM_DIGITS      = 10;
    localparam int unsigned BCD_BITS        = 4 * NUM_DIGITS;
    localparam int unsigned NUM_CELLS       = NUM_BITS;
    localparam logic [6:0]  MAX_FIELD_WIDTH = 7'd64;
    localparam logic [6:0]  RESET_WIDTH     = 7'd12;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_BLANK = 8'h20;

    typedef enum logic [1:0] {
        REG_FIELD_WIDTH = 2'd0,
        REG_MIN_DIGITS  = 2'd1,
        REG_FORCE_PLUS  = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [NUM_BITS-1:0] bin;
        logic [BCD_BITS-1:0] bcd;
        logic                neg;
    } t_cell_data;

    typedef struct packed {
        logic [6:0] field_width;
        logic [6:0] min_digits;
        logic       force_plus;
    } t_config;

endpackage

@@ hdl/ifdf_dabble_cell.sv @@
// One shift-and-add-3 cell of the binary to BCD converter chain.
// Depends on ifdf_pkg.
module ifdf_dabble_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ifdf_pkg::t_cell_data i_data,
    output logic                o_ready,
    output logic                o_valid,
    output ifdf_pkg::t_cell_data o_data,
    input  logic                i_ready
);

    logic                 r_valid;
    ifdf_pkg::t_cell_data r_data;
    ifdf_pkg::t_cell_data n_data;
    logic [ifdf_pkg::BCD_BITS-1:0] w_adj;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        for (int d = 0; d < ifdf_pkg::NUM_DIGITS; d++) begin
            if (i_data.bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = i_data.bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = i_data.bcd[4*d +: 4];
            end
        end
        n_data.bcd = {w_adj[ifdf_pkg::BCD_BITS-2:0], i_data.bin[ifdf_pkg::NUM_BITS-1]};
        n_data.bin = {i_data.bin[ifdf_pkg::NUM_BITS-2:0], 1'b0};
        n_data.neg = i_data.neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

@@ hdl/ifdf_serializer.sv @@
// Lays out one converted value as a right-aligned field and sends it one
// character per transfer. Depends on ifdf_pkg.
module ifdf_serializer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ifdf_pkg::t_config    i_cfg,
    input  logic                 i_valid,
    input  ifdf_pkg::t_cell_data i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    output logic [7:0]           o_character,
    output logic                 o_last,
    input  logic                 i_stall
);

    logic       r_busy;
    logic [ifdf_pkg::BCD_BITS-1:0] r_bcd;
    logic [6:0] r_w;
    logic [6:0] r_blank;
    logic       r_sign;
    logic       r_neg;
    logic       r_star;
    logic [5:0] r_pos;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;

    logic       w_adv;
    logic       w_final;
    logic       w_load;
    logic [3:0] w_ndig;
    logic [6:0] w_width;
    logic       w_sign;
    logic [6:0] w_zeros;
    logic [7:0] w_need;
    logic [6:0] w_k;
    logic [6:0] w_pos_ext;
    logic [7:0] n_char;

    assign w_adv   = !r_out_valid || !i_stall;
    assign w_final = r_busy && w_adv && (w_pos_ext == r_w - 7'd1);
    assign o_ready = !r_busy || w_final;
    assign w_load  = o_ready && i_valid;

    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;
    assign w_pos_ext   = {1'b0, r_pos};

    always_comb begin
        w_ndig = 4'd1;
        for (int d = 0; d < ifdf_pkg::NUM_DIGITS; d++) begin
            if (i_data.bcd[4*d +: 4] != 4'd0) begin
                w_ndig = 4'(d + 1);
            end
        end
        w_width = (i_cfg.field_width > ifdf_pkg::MAX_FIELD_WIDTH) ?
                  ifdf_pkg::MAX_FIELD_WIDTH : i_cfg.field_width;
        w_sign  = i_data.neg || i_cfg.force_plus;
        w_zeros = (i_cfg.min_digits > {3'd0, w_ndig}) ?
                  (i_cfg.min_digits - {3'd0, w_ndig}) : 7'd0;
        w_need  = {4'd0, w_ndig} + {7'd0, w_sign} + {1'b0, w_zeros};
    end

    always_comb begin
        w_k = r_w - 7'd1 - w_pos_ext;
        if (r_star) begin
            n_char = ifdf_pkg::CH_STAR;
        end else if (w_pos_ext < r_blank) begin
            n_char = ifdf_pkg::CH_BLANK;
        end else if (r_sign && (w_pos_ext == r_blank)) begin
            n_char = r_neg ? ifdf_pkg::CH_MINUS : ifdf_pkg::CH_PLUS;
        end else if (w_k < 7'(ifdf_pkg::NUM_DIGITS)) begin
            n_char = ifdf_pkg::CH_ZERO + {4'd0, r_bcd[4*w_k[3:0] +: 4]};
        end else begin
            n_char = ifdf_pkg::CH_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= 6'd0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_busy;
            end
            if (w_load) begin
                r_busy <= (w_width != 7'd0);
                r_pos  <= 6'd0;
            end else if (w_final) begin
                r_busy <= 1'b0;
            end else if (r_busy && w_adv) begin
                r_pos <= r_pos + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_busy) begin
            r_out_char <= n_char;
            r_out_last <= (w_pos_ext == r_w - 7'd1);
        end
        if (w_load) begin
            r_bcd   <= i_data.bcd;
            r_w     <= w_width;
            r_star  <= (w_need > {1'b0, w_width});
            r_blank <= w_width - w_need[6:0];
            r_sign  <= w_sign;
            r_neg   <= i_data.neg;
        end
    end

endmodule

@@ hdl/integer_fixed_width_decimal_formatter.sv @@
// Top level of the fixed-width decimal integer formatter: APB registers,
// converter cell chain and character serializer. Depends on ifdf_pkg,
// ifdf_dabble_cell and ifdf_serializer.
//
// Input channel: i_valid / o_stall carry one signed 32-bit i_number per transfer.
// Output channel: o_valid / i_stall carry one ASCII o_character per transfer,
// left to right, with o_last on the final character of each field.
// Each value gives exactly field_width characters (64 at most, none for zero).
// The path from input transfer to the first character runs through the 32 cells
// of the shift-and-add-3 chain, the serializer load and the output register.
// Throughput is one character per cycle while the receiver does not stall; the
// serializer emitting one character per cycle sets that figure.
// The cell chain holds up to 32 values in flight and takes a new one every
// cycle while it has room.
// When the receiver stalls, the output register holds its character and the
// chain fills, then o_stall rises. Reset empties the chain and the
// serializer and sets field_width 12, min_digits 0, force_plus 0.
// Registers must be written only while no value is in flight; the block does not enforce it.
module integer_fixed_width_decimal_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [31:0] i_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_character,
    output logic        o_last
);

    ifdf_pkg::t_config    r_cfg;
    ifdf_pkg::t_reg_index w_index;
    ifdf_pkg::t_cell_data w_first;

    logic                 w_valid [ifdf_pkg::NUM_CELLS+1];
    logic                 w_ready [ifdf_pkg::NUM_CELLS+1];
    ifdf_pkg::t_cell_data w_data  [ifdf_pkg::NUM_CELLS+1];

    assign pready  = 1'b1;
    assign w_index = ifdf_pkg::t_reg_index'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_width <= ifdf_pkg::RESET_WIDTH;
            r_cfg.min_digits  <= 7'd0;
            r_cfg.force_plus  <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (w_index)
                ifdf_pkg::REG_FIELD_WIDTH: r_cfg.field_width <= pwdata[6:0];
                ifdf_pkg::REG_MIN_DIGITS:  r_cfg.min_digits  <= pwdata[6:0];
                ifdf_pkg::REG_FORCE_PLUS:  r_cfg.force_plus  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            ifdf_pkg::REG_FIELD_WIDTH: prdata = {25'd0, r_cfg.field_width};
            ifdf_pkg::REG_MIN_DIGITS:  prdata = {25'd0, r_cfg.min_digits};
            ifdf_pkg::REG_FORCE_PLUS:  prdata = {31'd0, r_cfg.force_plus};
            default:                   prdata = 32'd0;
        endcase
    end

    always_comb begin
        w_first.neg = i_number[31];
        w_first.bin = i_number[31] ? (32'd0 - i_number) : i_number;
        w_first.bcd = '0;
    end

    assign w_valid[0] = i_valid;
    assign w_data[0]  = w_first;
    assign o_stall    = !w_ready[0];

    for (genvar k = 0; k < ifdf_pkg::NUM_CELLS; k++) begin : g_cell
        ifdf_dabble_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_data  (w_data[k]),
            .o_ready (w_ready[k]),
            .o_valid (w_valid[k+1]),
            .o_data  (w_data[k+1]),
            .i_ready (w_ready[k+1])
        );
    end

    ifdf_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (w_valid[ifdf_pkg::NUM_CELLS]),
        .i_data      (w_data[ifdf_pkg::NUM_CELLS]),
        .o_ready     (w_ready[ifdf_pkg::NUM_CELLS]),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last),
        .i_stall     (i_stall)
    );

endmodule

@@ test/tb_integer_fixed_width_decimal_formatter.sv @@
`timescale 1ns / 1ps
// Testbench for integer_fixed_width_decimal_formatter: writes field settings over APB,
// formats numbers under random idling and stalls, and checks every character.
// Depends on ifdf_pkg and the formatter RTL.
module tb_integer_fixed_width_decimal_formatter;

    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 260;
    localparam int QUIET_LIMIT   = 3000;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_expected_char;

    class field_board;
        int unsigned    width_reg;
        int unsigned    min_reg;
        int unsigned    plus_reg;
        t_expected_char pending_chars[$];
        int unsigned    errors;
        int unsigned    chars_checked;

        function new();
            width_reg = 12;
            min_reg = 0;
            plus_reg = 0;
            errors = 0;
            chars_checked = 0;
        endfunction

        function void set_reg(ifdf_pkg::t_reg_index idx, logic [31:0] value);
            case (idx)
                ifdf_pkg::REG_FIELD_WIDTH: width_reg = 32'(value[6:0]);
                ifdf_pkg::REG_MIN_DIGITS:  min_reg = 32'(value[6:0]);
                ifdf_pkg::REG_FORCE_PLUS:  plus_reg = 32'(value[0]);
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return pending_chars.size();
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, what);
        endtask

        // Expected field for one accepted number.
        function void note_number(logic [31:0] raw);
            logic           neg;
            logic [31:0]    mag;
            logic [3:0]     dig [10];
            logic [7:0]     field [64];
            int unsigned    ndig, w, sign_len, zeros, need, pos, i;
            t_expected_char e;
            w = (width_reg > 32'(ifdf_pkg::MAX_FIELD_WIDTH)) ?
                32'(ifdf_pkg::MAX_FIELD_WIDTH) : width_reg;
            if (w == 0) return;
            neg = raw[31];
            mag = neg ? (32'd0 - raw) : raw;
            ndig = 0;
            do begin
                dig[ndig] = 4'(mag % 32'd10);
                mag = mag / 32'd10;
                ndig++;
            end while (mag != 0 && ndig < 10);
            sign_len = (neg || plus_reg != 0) ? 1 : 0;
            zeros = (min_reg > ndig) ? (min_reg - ndig) : 0;
            need = ndig + sign_len + zeros;
            pos = 0;
            if (need > w) begin
                for (i = 0; i < w; i++) field[i] = ifdf_pkg::CH_STAR;
            end else begin
                for (i = 0; i < w - need; i++) begin
                    field[pos] = ifdf_pkg::CH_BLANK;
                    pos++;
                end
                if (sign_len != 0) begin
                    field[pos] = neg ? ifdf_pkg::CH_MINUS : ifdf_pkg::CH_PLUS;
                    pos++;
                end
                for (i = 0; i < zeros; i++) begin
                    field[pos] = ifdf_pkg::CH_ZERO;
                    pos++;
                end
                for (i = ndig; i > 0; i--) begin
                    field[pos] = ifdf_pkg::CH_ZERO + 8'(dig[i-1]);
                    pos++;
                end
            end
            for (i = 0; i < w; i++) begin
                e.ch = field[i];
                e.last = (i + 1 == w);
                pending_chars.push_back(e);
            end
        endfunction

        task check_char(logic [7:0] ch, logic last);
            t_expected_char e;
            if (pending_chars.size() == 0) begin
                report($sformatf("unexpected character 0x%02h last %0b", ch, last));
            end else begin
                e = pending_chars.pop_front();
                chars_checked++;
                if (ch !== e.ch)
                    report($sformatf("character 0x%02h, expected 0x%02h", ch, e.ch));
                if (last !== e.last)
                    report($sformatf("last %0b, expected %0b", last, e.last));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic signed [31:0] i_number;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_character;
    logic        o_last;

    field_board  board = new();
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_requests = 0;
    int          holds_done = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int unsigned numbers_in = 0;
    int unsigned settings_used = 0;

    integer_fixed_width_decimal_formatter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_number    (i_number),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_requests != holds_done) begin
            holds_done <= holds_done + 1;
            hold_left <= HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Transfer monitor and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                board.note_number(i_number);
                numbers_in++;
            end
            if (o_valid && !i_stall) board.check_char(o_character, o_last);
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("tb_integer_fixed_width_decimal_formatter: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_number(input logic [31:0] n);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_number <= n;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic reg_write(input ifdf_pkg::t_reg_index idx, input logic [31:0] value);
        logic [31:0] junk;
        junk = $urandom;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= (idx == ifdf_pkg::REG_FORCE_PLUS) ? {junk[31:1], value[0]} :
                  {junk[31:7], value[6:0]};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_reg(idx, value);
    endtask

    task automatic configure(input int unsigned w, input int unsigned m, input int unsigned p);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        reg_write(ifdf_pkg::REG_FIELD_WIDTH, w);
        reg_write(ifdf_pkg::REG_MIN_DIGITS, m);
        reg_write(ifdf_pkg::REG_FORCE_PLUS, p);
        settings_used++;
    endtask

    function automatic logic [31:0] pick_number();
        logic [31:0] v;
        logic [31:0] p10 [10] = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
                                 32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000};
        case ($urandom_range(5))
            0: v = $urandom_range(199) - 100;
            1: begin
                v = p10[$urandom_range(9)] + $urandom_range(2) - 1;
                if ($urandom_range(1)) v = 32'd0 - v;
            end
            2: begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'd0;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic random_setup();
        int unsigned w, m;
        case ($urandom_range(9))
            0: w = 0;
            1: w = 64;
            2: w = $urandom_range(127, 65);
            3: w = 1;
            default: w = $urandom_range(16, 2);
        endcase
        case ($urandom_range(5))
            0: m = $urandom_range(127, 13);
            1: m = 0;
            default: m = $urandom_range(12);
        endcase
        configure(w, m, $urandom_range(1));
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_number = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_gap_pct = 20;
        recv_stall_pct = 85;

        // Reset settings: width 12, no padding, no forced sign.
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'hFFFF_FFFF);
        send_number(32'h7FFF_FFFF);
        send_number(32'h8000_0000);
        send_number(32'd123456789);
        send_number(32'd0 - 32'd1000000000);
        // Narrowest field, overflow to asterisks.
        configure(1, 0, 0);
        send_number(32'd0);
        send_number(32'd5);
        send_number(32'd0 - 32'd5);
        send_number(32'd10);
        // Width above maximum saturates.
        configure(127, 63, 1);
        send_number(32'd0);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        configure(64, 64, 0);
        send_number(32'd5);
        configure(20, 127, 0);
        send_number(32'd5);
        // Zero width gives no characters.
        configure(0, 0, 1);
        send_number(32'd77);
        send_number(32'h8000_0000);
        send_number(32'd0);
        // Exact fit of the widest values.
        configure(11, 10, 1);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        send_number(32'd0);

        for (int ph = 0; ph < 3; ph++) begin
            send_gap_pct = (ph == 0) ? 20 : (ph == 1) ? 85 : 0;
            recv_stall_pct = (ph == 0) ? 85 : (ph == 1) ? 20 : 0;
            for (int seg = 0; seg < 3; seg++) begin
                random_setup();
                repeat (12) send_number(pick_number());
            end
        end

        // Long receiver hold-off while numbers keep coming.
        configure(2, 0, 1);
        hold_requests <= hold_requests + 1;
        repeat (48) send_number(pick_number());
        i_valid <= 1'b0;
        @(posedge i_clk);

        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.outstanding() != 0)
            board.report($sformatf("%0d characters never arrived", board.outstanding()));
        $display("covered %0d numbers under %0d register settings, %0d characters checked",
                 numbers_in, settings_used, board.chars_checked);
        $display("idling mixes: sender-light, receiver-light, none; one long receiver hold-off");
        if (board.errors == 0) begin
            $display("tb_integer_fixed_width_decimal_formatter: clean");
        end else begin
            $display("tb_integer_fixed_width_decimal_formatter: errors");
        end
        $finish;
    end

endmodule
